// ===== rtl/core/ghacc_pkg.sv =====
// Shared widths, constants and types of the GHASH accumulator.
package ghacc_pkg;

	// Field widths.
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned BYTES   = 16;

	// Configuration register indexes.
	localparam logic CFG_SUBKEY_HIGH = 1'b0;
	localparam logic CFG_SUBKEY_LOW  = 1'b1;

	// Width of the product before reduction.
	localparam int unsigned PROD_W = 2 * BLOCK_W - 1;

	// Overflow bits left after the first fold.
	localparam int unsigned FOLD_W = 6;

	// One masked block ready to be absorbed.
	typedef struct packed {
		logic [BLOCK_W-1:0] block;     // bytes past the count forced to zero
		logic               start_new; // clear the accumulator first
		logic               absorb;    // nonzero count: XOR in and multiply
	} ghacc_item_t;

endpackage

// ===== rtl/core/ghacc_block_mask.sv =====
// Input masking: zero-pads the block past its byte count and flags an empty request.
module ghacc_block_mask (
	input  logic [ghacc_pkg::HALF_W-1:0]  block_high,
	input  logic [ghacc_pkg::HALF_W-1:0]  block_low,
	input  logic [ghacc_pkg::COUNT_W-1:0] byte_count,
	input  logic                          start_new,
	output ghacc_pkg::ghacc_item_t        item
);

	logic [ghacc_pkg::BLOCK_W-1:0] raw;
	logic [ghacc_pkg::BLOCK_W-1:0] mask;

	assign raw = {block_high, block_low};

	// Byte k sits in the top bits for k = 0; it is kept when k is below the count.
	// A count above sixteen keeps every byte, which matches saturation.
	always_comb begin
		mask = '0;
		for (int k = 0; k < int'(ghacc_pkg::BYTES); k++) begin
			mask[ghacc_pkg::BLOCK_W-1-8*k -: 8] = {8{byte_count > ghacc_pkg::COUNT_W'(k)}};
		end
	end

	// A zero count absorbs nothing.
	assign item.block     = raw & mask;
	assign item.start_new = start_new;
	assign item.absorb    = (byte_count != '0);

endmodule

// ===== rtl/core/ghacc_gfmul.sv =====
// Combinational GF(2^128) multiplier in the GCM bit-reflected convention.
module ghacc_gfmul (
	input  logic [ghacc_pkg::BLOCK_W-1:0] op_x,
	input  logic [ghacc_pkg::BLOCK_W-1:0] op_h,
	output logic [ghacc_pkg::BLOCK_W-1:0] product
);

	localparam int unsigned W = ghacc_pkg::BLOCK_W;
	localparam int unsigned P = ghacc_pkg::PROD_W;
	localparam int unsigned F = ghacc_pkg::FOLD_W;

	logic [W-1:0]     a_rev;
	logic [W-1:0]     b_rev;
	logic [P-1:0]     prod;
	logic [W+F-1:0]   hi;
	logic [W+F-1:0]   fold1;
	logic [F+7-1:0]   ovf;
	logic [F+7-1:0]   fold2;
	logic [W-1:0]     red;

	// Bit 127 of the word is the coefficient of x^0, so reverse into polynomial order.
	always_comb begin
		for (int i = 0; i < int'(W); i++) begin
			a_rev[i] = op_x[W-1-i];
			b_rev[i] = op_h[W-1-i];
		end
	end

	// Carry-less product: each coefficient is an independent XOR of AND terms.
	always_comb begin
		prod = '0;
		for (int k = 0; k < int'(P); k++) begin
			for (int i = 0; i < int'(W); i++) begin
				if ((k - i >= 0) && (k - i < int'(W))) begin
					prod[k] = prod[k] ^ (a_rev[i] & b_rev[k-i]);
				end
			end
		end
	end

	// Reduce with x^128 = x^7 + x^2 + x + 1, folding the high half twice.
	assign hi    = {{(F+1){1'b0}}, prod[P-1:W]};
	assign fold1 = hi ^ (hi << 1) ^ (hi << 2) ^ (hi << 7);
	assign ovf   = {7'b0, fold1[W+F-1:W]};
	assign fold2 = ovf ^ (ovf << 1) ^ (ovf << 2) ^ (ovf << 7);
	assign red   = prod[W-1:0] ^ fold1[W-1:0] ^ {{(W-F-7){1'b0}}, fold2};

	// Back to the reflected word order.
	always_comb begin
		for (int i = 0; i < int'(W); i++) begin
			product[i] = red[W-1-i];
		end
	end

endmodule

// ===== rtl/core/ghash_accumulator_core.sv =====
// Top level of the GHASH accumulator: input stage, multiply-accumulate and result register.
//
//  Channel   Signals                                          Direction
//  -------   ----------------------------------------------   ---------
//  in        in_valid/in_ready, block_high/low, byte_count,    into core
//            start_new
//  out       out_valid/out_ready, hash_high/low                out of core
//  cfg       cfg_wr_en, cfg_addr, cfg_wdata                    into core
//
// One request is taken every cycle while the result is not stalled; it is registered in the
// input stage, then its result in the accumulator, and the result is offered from then on.
// The rate is set by the combinational GF(2^128) multiplier in the accumulator loop.
// Reset clears the subkey, the accumulator and both valid flags.
// While the result waits, one more request is held in the input stage; further
// requests stall until the result is taken.
module ghash_accumulator_core (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ghacc_pkg::HALF_W-1:0]   block_high,
	input  logic [ghacc_pkg::HALF_W-1:0]   block_low,
	input  logic [ghacc_pkg::COUNT_W-1:0]  byte_count,
	input  logic                           start_new,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ghacc_pkg::HALF_W-1:0]   hash_high,
	output logic [ghacc_pkg::HALF_W-1:0]   hash_low,

	input  logic                           cfg_wr_en,
	input  logic                           cfg_addr,
	input  logic [ghacc_pkg::HALF_W-1:0]   cfg_wdata
);

	localparam int unsigned W = ghacc_pkg::BLOCK_W;
	localparam int unsigned H = ghacc_pkg::HALF_W;

	ghacc_pkg::ghacc_item_t item_in;
	ghacc_pkg::ghacc_item_t item_s1;
	logic                   valid_s1;
	logic                   fire_s1;

	logic [H-1:0] subkey_high_q;
	logic [H-1:0] subkey_low_q;
	logic [W-1:0] acc_q;
	logic         out_valid_q;

	logic [W-1:0] acc_base;
	logic [W-1:0] mul_x;
	logic [W-1:0] mul_p;
	logic [W-1:0] acc_next;

	// Subkey registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subkey_high_q <= '0;
			subkey_low_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				ghacc_pkg::CFG_SUBKEY_HIGH: subkey_high_q <= cfg_wdata;
				ghacc_pkg::CFG_SUBKEY_LOW:  subkey_low_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Mask the incoming block.
	ghacc_block_mask u_mask (
		.block_high (block_high),
		.block_low  (block_low),
		.byte_count (byte_count),
		.start_new  (start_new),
		.item       (item_in)
	);

	// The stage moves into the result register when that register is free or being drained.
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
	end

	// Multiply-accumulate: clear on start, XOR in the block, multiply by H.
	assign acc_base = item_s1.start_new ? '0 : acc_q;
	assign mul_x    = acc_base ^ item_s1.block;

	ghacc_gfmul u_gfmul (
		.op_x    (mul_x),
		.op_h    ({subkey_high_q, subkey_low_q}),
		.product (mul_p)
	);

	assign acc_next = item_s1.absorb ? mul_p : acc_base;

	// The accumulator doubles as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				acc_q <= acc_next;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hash_high = acc_q[W-1:H];
	assign hash_low  = acc_q[H-1:0];

	// A blocked result keeps the held request in the input stage.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> valid_s1)
		else $error("input stage lost a request while the result was blocked");

	// The accumulator only changes when a request completes.
	a_acc_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(acc_q))
		else $error("accumulator changed without a completing request");

	// An empty start request leaves a zero hash.
	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.start_new && !item_s1.absorb) |=> (acc_q == '0))
		else $error("empty start request did not clear the accumulator");

	// A new result appears only after the input stage hands one over.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire_s1))
		else $error("result flagged without a completed request");

endmodule
